// ===== rtl/ptw_pkg.sv =====
// Shared widths, codes, the walk step record and the table word address function.
package ptw_pkg;

	localparam int unsigned PA_W = 52;
	localparam int unsigned VA_W = 48;
	localparam int unsigned ENTRY_W = 64;
	localparam int unsigned WIDX_W = 12;
	localparam int unsigned FRAME_W = 40;
	localparam int unsigned LVL_IDX_W = 9;
	localparam int unsigned MAX_ADDR_W = 16;
	localparam int unsigned TABLE_WORDS_DEF = 4096;

	localparam int unsigned BIT_PRESENT = 0;
	localparam int unsigned BIT_HUGE = 7;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_XLATE = 1'b1;

	typedef enum logic [1:0] {
		PG_4K = 2'd0,
		PG_2M = 2'd1,
		PG_1G = 2'd2
	} leaf_size_t;

	// Level of the entry just read from the store.
	typedef enum logic [1:0] {
		LVL_4K = 2'd0,
		LVL_2M = 2'd1,
		LVL_1G = 2'd2,
		LVL_ROOT = 2'd3
	} level_t;

	typedef struct packed {
		logic done;
		logic present;
		leaf_size_t leaf_size;
		logic [PA_W-1:0] phys_addr;
		logic [FRAME_W-1:0] next_frame;
		logic [LVL_IDX_W-1:0] next_idx;
	} step_t;

	// Word of a table entry: (table address >> 3) + index. The table is 4KB
	// aligned, so the index fills the low nine bits with no carry.
	function automatic logic [MAX_ADDR_W-1:0] word_addr(
		input logic [FRAME_W-1:0] frame,
		input logic [LVL_IDX_W-1:0] idx
	);
		return {frame[MAX_ADDR_W-LVL_IDX_W-1:0], idx};
	endfunction

endpackage

// ===== rtl/ptw_if.sv =====
// Request and response channel interfaces of the page table walker.
interface ptw_req_if import ptw_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	logic [VA_W-1:0] virt_addr;
	logic [WIDX_W-1:0] word_index;
	logic [ENTRY_W-1:0] entry_data;

	modport source (output valid, kind, virt_addr, word_index, entry_data, input ready);
	modport sink (input valid, kind, virt_addr, word_index, entry_data, output ready);
endinterface

interface ptw_rsp_if import ptw_pkg::*; ();
	logic valid;
	logic ready;
	logic [PA_W-1:0] phys_addr;
	logic present;
	logic [1:0] leaf_size;

	modport source (output valid, phys_addr, present, leaf_size, input ready);
	modport sink (input valid, phys_addr, present, leaf_size, output ready);
endinterface

// ===== rtl/ptw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
module ptw_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ptw_level_unit.sv =====
// Shared level unit: checks one fetched entry and forms the next pointer or the leaf address.
module ptw_level_unit import ptw_pkg::*; (
	input  level_t               level,
	input  logic [ENTRY_W-1:0]   entry,
	input  logic [VA_W-1:0]      virt_addr,
	output step_t                step
);

	always_comb begin
		step = '0;
		step.next_frame = entry[PA_W-1:12];
		if (!entry[BIT_PRESENT]) begin
			step.done = 1'b1;
		end else begin
			unique case (level)
				LVL_ROOT: begin
					step.next_idx = virt_addr[38:30];
				end
				LVL_1G: begin
					if (entry[BIT_HUGE]) begin
						step.done = 1'b1;
						step.present = 1'b1;
						step.leaf_size = PG_1G;
						step.phys_addr = {entry[PA_W-1:30], virt_addr[29:0]};
					end else begin
						step.next_idx = virt_addr[29:21];
					end
				end
				LVL_2M: begin
					if (entry[BIT_HUGE]) begin
						step.done = 1'b1;
						step.present = 1'b1;
						step.leaf_size = PG_2M;
						step.phys_addr = {entry[PA_W-1:21], virt_addr[20:0]};
					end else begin
						step.next_idx = virt_addr[20:12];
					end
				end
				LVL_4K: begin
					step.done = 1'b1;
					step.present = 1'b1;
					step.leaf_size = PG_4K;
					step.phys_addr = {entry[PA_W-1:12], virt_addr[11:0]};
				end
				default: begin
					step.done = 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== rtl/four_level_page_table_walker_top.sv =====
// Four-level page table walker: a local table store and a walk sequencer around one level unit.
// After reset the block clears its table store, one word per cycle, over all TABLE_WORDS words
// (TABLE_WORDS is a power of two from 512 to 65536) and takes no request until that pass ends.
// A write request stores one entry and returns nothing. A translate request makes one read of
// the store per level, one level per cycle through the store's single read port. The walk ends
// at the root on a fault there, at the 1GB level for a 1GB leaf or a fault at that level, at
// the 2MB level for a 2MB leaf or a fault at that level, or at the 4KB level; the result is
// registered and the next request can be taken in the cycle in which it becomes valid. A
// finished result waits in the output register while further requests are taken; a second
// translation holds at its last level until that register frees up.
module four_level_page_table_walker_top import ptw_pkg::*; #(
	parameter int unsigned TABLE_WORDS = TABLE_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [PA_W-1:0]   cfg_wr_data,
	ptw_req_if.sink           req,
	ptw_rsp_if.source         rsp
);

	localparam int unsigned AW = $clog2(TABLE_WORDS);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_cnt_q;
	level_t level_q;
	logic [VA_W-1:0] va_q;
	logic [FRAME_W-1:0] root_frame_q;
	logic rsp_valid_q;
	logic [PA_W-1:0] pa_q;
	logic present_q;
	leaf_size_t size_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	step_t step;
	logic req_xfer;
	logic out_free;
	logic walk_done;

	ptw_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ptw_level_unit u_level (
		.level     (level_q),
		.entry     (ram_rdata),
		.virt_addr (va_q),
		.step      (step)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign walk_done = (state_q == ST_WALK) && step.done && out_free;

	assign rsp.valid = rsp_valid_q;
	assign rsp.phys_addr = pa_q;
	assign rsp.present = present_q;
	assign rsp.leaf_size = size_q;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = clr_cnt_q;
		ram_wdata = '0;
		ram_re = 1'b0;
		ram_raddr = AW'(word_addr(step.next_frame, step.next_idx));
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				if (req_xfer && req.kind == KIND_WRITE) begin
					ram_we = 1'b1;
					ram_waddr = AW'(req.word_index);
					ram_wdata = req.entry_data;
				end
				if (req_xfer && req.kind == KIND_XLATE) begin
					ram_re = 1'b1;
					ram_raddr = AW'(word_addr(root_frame_q, req.virt_addr[47:39]));
				end
			end
			ST_WALK: begin
				ram_re = !step.done;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_frame_q <= '0;
		end else if (cfg_wr_en) begin
			root_frame_q <= cfg_wr_data[PA_W-1:12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_cnt_q <= '0;
			level_q <= LVL_ROOT;
			rsp_valid_q <= 1'b0;
		end else begin
			if (walk_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(TABLE_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_xfer && req.kind == KIND_XLATE) begin
						level_q <= LVL_ROOT;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (step.done) begin
						// hold the last entry until the output register frees up
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						level_q <= level_t'(level_q - 2'd1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			va_q <= req.virt_addr;
		end
		if (walk_done) begin
			pa_q <= step.phys_addr;
			present_q <= step.present;
			size_q <= step.leaf_size;
		end
	end

`ifndef SYNTHESIS
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.present |-> rsp.phys_addr == '0 && rsp.leaf_size == PG_4K)
		else $error("fault result carries a nonzero address or size");

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> !ram_we)
		else $error("table store written during a walk");

	a_level_descends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK && $past(state_q) == ST_WALK && !$past(step.done)
		|-> level_q == level_t'($past(level_q) - 2'd1))
		else $error("walk level did not descend by one");
`endif

endmodule
